/* design/pl0ts_pkg.sv */
// Shared constants, codes and keyword tables for the PL/0 token scanner.
package pl0ts_pkg;

    // Default widths of the number and line fields
    localparam int NUMBER_BITS_DEF = 63;
    localparam int LINE_BITS_DEF   = 32;

    // Field widths fixed by the token format
    localparam int CHAR_BITS = 8;
    localparam int KIND_BITS = 4;
    localparam int ERR_BITS  = 3;
    localparam int USER_BITS = KIND_BITS + ERR_BITS;

    // Result queue depth
    localparam int RQ_DEPTH = 4;

    // Token kinds
    localparam logic [KIND_BITS-1:0] KIND_END     = 4'd0;
    localparam logic [KIND_BITS-1:0] KIND_IDENT   = 4'd1;
    localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 4'd2;
    localparam logic [KIND_BITS-1:0] KIND_KW_BASE = 4'd3;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN  = 4'd14;
    localparam logic [KIND_BITS-1:0] KIND_PUNCT   = 4'd15;

    // Error codes
    localparam logic [ERR_BITS-1:0] ERR_NONE         = 3'd0;
    localparam logic [ERR_BITS-1:0] ERR_OPEN_COMMENT = 3'd1;
    localparam logic [ERR_BITS-1:0] ERR_BAD_COLON    = 3'd2;
    localparam logic [ERR_BITS-1:0] ERR_UNKNOWN_CHAR = 3'd3;
    localparam logic [ERR_BITS-1:0] ERR_OVERFLOW     = 3'd4;

    // Scanner modes
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_NAME    = 5'b00010,
        MODE_NUM     = 5'b00100,
        MODE_COLON   = 5'b01000,
        MODE_COMMENT = 5'b10000
    } scan_mode_t;

    // Keyword table, in token kind order
    localparam int KW_COUNT    = 11;
    localparam int KW_MAX_LEN  = 9;
    localparam int NAME_LEN_BITS = 4;

    localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
        "const", "var", "procedure", "call", "begin", "end",
        "if", "then", "while", "do", "odd"
    };
    localparam logic [NAME_LEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
        4'd5, 4'd3, 4'd9, 4'd4, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd2, 4'd3
    };

    // Character of keyword kw at position pos; zero past its end
    function automatic logic [7:0] kw_char(input logic [3:0] kw,
                                           input logic [NAME_LEN_BITS-1:0] pos);
        logic [NAME_LEN_BITS-1:0] len;
        logic [NAME_LEN_BITS-1:0] back;
        logic [7:0]               ch;
        len  = KW_LEN[kw];
        back = len - pos - 4'd1;
        ch   = 8'h00;
        if (pos < len) begin
            ch = KW_TEXT[kw][{back, 3'b000} +: 8];
        end
        return ch;
    endfunction

endpackage

/* design/pl0ts_result_queue.sv */
// Small result queue: takes up to two results per cycle, hands out one.
module pl0ts_result_queue #(
    parameter int ITEM_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           wr_cnt,
    input  logic [ITEM_BITS-1:0] wr_data0,
    input  logic [ITEM_BITS-1:0] wr_data1,
    output logic                 room,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output logic [ITEM_BITS-1:0] rd_data
);

    localparam int PTR_BITS = $clog2(pl0ts_pkg::RQ_DEPTH);
    localparam int CNT_BITS = $clog2(pl0ts_pkg::RQ_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] ROOM_LIMIT = CNT_BITS'(pl0ts_pkg::RQ_DEPTH - 2);

    logic [ITEM_BITS-1:0] mem [pl0ts_pkg::RQ_DEPTH];
    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 pop;
    logic [PTR_BITS-1:0]  wr_ptr_plus1;

    assign pop          = rd_valid && rd_ready;
    assign room         = (count_reg <= ROOM_LIMIT);
    assign rd_valid     = (count_reg != '0);
    assign rd_data      = mem[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_BITS'(1);

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(wr_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(wr_cnt) - CNT_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store incoming results
    always_ff @(posedge aclk) begin
        if (wr_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= wr_data0;
        end
        if (wr_cnt == 2'd2) begin
            mem[wr_ptr_plus1] <= wr_data1;
        end
    end

endmodule

/* design/pl0_token_scanner_core.sv */
// PL/0 token scanner top level: character stream in, token stream out.
//
//  channel | dir | payload                                    | end marker
//  s_      | in  | tdata: char_code                           | -
//  m_      | out | tdata: token_char, number_value, line_num  | tlast: last result
//          |     | tuser: token_kind, error_code              |   of the character
//
// A character is registered, scanned combinationally and its zero, one or two
// results are written into a four-entry result queue. One character is taken
// every cycle while the queue has room for two results; output stalls back up
// through the queue and then the input register. Reset (synchronous, aresetn
// low) returns the scanner to idle at line one and clears the halt after an
// error. After an error every further character is taken and dropped.
module pl0_token_scanner_core #(
    parameter int NUMBER_BITS = pl0ts_pkg::NUMBER_BITS_DEF,
    parameter int LINE_BITS   = pl0ts_pkg::LINE_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_code
    output logic                m_tvalid,
    input  logic                m_tready,
    // [7:0] token_char, then number_value, then line_number, zero padded
    output logic [((pl0ts_pkg::CHAR_BITS + NUMBER_BITS + LINE_BITS + 7) / 8) * 8 - 1:0]
                                m_tdata,
    output logic [6:0]          m_tuser,   // [3:0] token_kind, [6:4] error_code
    output logic                m_tlast    // last_of_run
);

    localparam int CB        = pl0ts_pkg::CHAR_BITS;
    localparam int KB        = pl0ts_pkg::KIND_BITS;
    localparam int EB        = pl0ts_pkg::ERR_BITS;
    localparam int LB        = pl0ts_pkg::NAME_LEN_BITS;
    localparam int KWC       = pl0ts_pkg::KW_COUNT;
    localparam int DATA_BITS = ((CB + NUMBER_BITS + LINE_BITS + 7) / 8) * 8;
    localparam int PAD_BITS  = DATA_BITS - (CB + NUMBER_BITS + LINE_BITS);
    localparam int ITEM_BITS = CB + NUMBER_BITS + LINE_BITS + pl0ts_pkg::USER_BITS + 1;
    localparam int PROD_BITS = NUMBER_BITS + 4;

    typedef struct packed {
        logic                   last;
        logic [EB-1:0]          err;
        logic [KB-1:0]          kind;
        logic [LINE_BITS-1:0]   line;
        logic [NUMBER_BITS-1:0] value;
        logic [CB-1:0]          ch;
    } result_t;

    // Input register
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       advance;
    logic       q_room;

    // Scanner state
    pl0ts_pkg::scan_mode_t  mode_reg, mode_next;
    logic [KWC-1:0]         cand_reg, cand_next;
    logic [LB-1:0]          name_len_reg, name_len_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic                   halted_reg, halted_next;

    logic [7:0] c;
    logic       c_alpha, c_digit, c_blank, c_punct;
    logic [3:0] c_digit_val;

    // Idle-mode scan of the current character
    logic                  idle_emit, idle_halt, idle_bump, idle_name, idle_num;
    logic [KB-1:0]         idle_kind;
    logic [CB-1:0]         idle_ch;
    logic [EB-1:0]         idle_err;
    pl0ts_pkg::scan_mode_t idle_mode;

    // Name tracking
    logic           name_start, name_upd;
    logic [LB-1:0]  nc_pos;
    logic [KWC-1:0] nc_mask;
    logic [KB-1:0]  name_kind;

    // Number tracking
    logic [PROD_BITS-1:0] prod;
    logic                 prod_ovf;

    // Results of this character
    logic          pre_v, do_idle, pre_halt, comment_bump;
    logic [KB-1:0] pre_kind;
    logic [EB-1:0] pre_err;
    logic [NUMBER_BITS-1:0] pre_value;
    logic [1:0]    res_cnt;
    result_t       res0, res1, q_out;

    assign advance  = in_vld_reg && q_room;
    assign s_tready = !in_vld_reg || advance;
    assign c        = in_char_reg;

    // Hold the incoming character until the scanner takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
        end
    end

    // Classify the character
    always_comb begin
        c_alpha     = (c inside {["a":"z"], ["A":"Z"]});
        c_digit     = (c inside {["0":"9"]});
        c_blank     = (c == " ") || (c == 8'h09);
        c_punct     = (c inside {".", "=", ",", ";", "#", "<", ">",
                                 "+", "-", "*", "/", "(", ")"});
        c_digit_val = 4'(c - "0");
    end

    // Scan one character from idle
    always_comb begin
        idle_emit = 1'b0;
        idle_halt = 1'b0;
        idle_bump = 1'b0;
        idle_name = 1'b0;
        idle_num  = 1'b0;
        idle_kind = pl0ts_pkg::KIND_END;
        idle_ch   = '0;
        idle_err  = pl0ts_pkg::ERR_NONE;
        idle_mode = pl0ts_pkg::MODE_IDLE;
        if (c_blank) begin
            idle_mode = pl0ts_pkg::MODE_IDLE;
        end else if (c == 8'h0a) begin
            idle_bump = 1'b1;
        end else if (c_alpha || c == "_") begin
            idle_mode = pl0ts_pkg::MODE_NAME;
            idle_name = 1'b1;
        end else if (c_digit) begin
            idle_mode = pl0ts_pkg::MODE_NUM;
            idle_num  = 1'b1;
        end else if (c == "{") begin
            idle_mode = pl0ts_pkg::MODE_COMMENT;
        end else if (c == ":") begin
            idle_mode = pl0ts_pkg::MODE_COLON;
        end else if (c == 8'h00) begin
            idle_emit = 1'b1;
        end else if (c_punct) begin
            idle_emit = 1'b1;
            idle_kind = pl0ts_pkg::KIND_PUNCT;
            idle_ch   = c;
        end else begin
            idle_emit = 1'b1;
            idle_halt = 1'b1;
            idle_err  = pl0ts_pkg::ERR_UNKNOWN_CHAR;
        end
    end

    // Narrow the keyword candidates by the character at the current position
    always_comb begin
        nc_pos  = name_start ? '0 : name_len_reg;
        nc_mask = name_start ? '1 : cand_reg;
        for (int i = 0; i < KWC; i++) begin
            if (pl0ts_pkg::kw_char(4'(i), nc_pos) != c) begin
                nc_mask[i] = 1'b0;
            end
        end
    end

    // Pick the keyword that still matches at the full length
    always_comb begin
        name_kind = pl0ts_pkg::KIND_IDENT;
        for (int i = KWC - 1; i >= 0; i--) begin
            if (cand_reg[i] && pl0ts_pkg::KW_LEN[i] == name_len_reg) begin
                name_kind = pl0ts_pkg::KIND_KW_BASE + KB'(i);
            end
        end
    end

    // Multiply by ten and add the digit; overflow when the top bits are set
    always_comb begin
        prod     = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                 + PROD_BITS'(c_digit_val);
        prod_ovf = (prod[PROD_BITS-1:NUMBER_BITS] != 4'b0);
    end

    // Mode dispatch: a result ahead of the idle scan, then the idle scan
    always_comb begin
        pre_v        = 1'b0;
        pre_halt     = 1'b0;
        pre_kind     = pl0ts_pkg::KIND_END;
        pre_err      = pl0ts_pkg::ERR_NONE;
        pre_value    = '0;
        do_idle      = 1'b0;
        comment_bump = 1'b0;
        name_start   = 1'b0;
        name_upd     = 1'b0;
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        case (mode_reg)
            pl0ts_pkg::MODE_NAME: begin
                if (c_alpha || c_digit || c == "_") begin
                    name_upd = 1'b1;
                end else begin
                    pre_v    = 1'b1;
                    pre_kind = name_kind;
                    do_idle  = 1'b1;
                end
            end
            pl0ts_pkg::MODE_NUM: begin
                if (c_digit) begin
                    if (!ovf_reg) begin
                        if (prod_ovf) begin
                            ovf_next = 1'b1;
                        end else begin
                            acc_next = prod[NUMBER_BITS-1:0];
                        end
                    end
                end else if (c != "_") begin
                    pre_v = 1'b1;
                    if (ovf_reg) begin
                        pre_halt  = 1'b1;
                        pre_err   = pl0ts_pkg::ERR_OVERFLOW;
                        mode_next = pl0ts_pkg::MODE_IDLE;
                    end else begin
                        pre_kind  = pl0ts_pkg::KIND_NUMBER;
                        pre_value = acc_reg;
                        do_idle   = 1'b1;
                    end
                end
            end
            pl0ts_pkg::MODE_COLON: begin
                pre_v     = 1'b1;
                mode_next = pl0ts_pkg::MODE_IDLE;
                if (c == "=") begin
                    pre_kind = pl0ts_pkg::KIND_ASSIGN;
                end else begin
                    pre_halt = 1'b1;
                    pre_err  = pl0ts_pkg::ERR_BAD_COLON;
                end
            end
            pl0ts_pkg::MODE_COMMENT: begin
                if (c == "}") begin
                    mode_next = pl0ts_pkg::MODE_IDLE;
                end else if (c == 8'h00) begin
                    mode_next = pl0ts_pkg::MODE_IDLE;
                    pre_v     = 1'b1;
                    pre_halt  = 1'b1;
                    pre_err   = pl0ts_pkg::ERR_OPEN_COMMENT;
                end else if (c == 8'h0a) begin
                    comment_bump = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            mode_next  = idle_mode;
            name_start = idle_name;
            name_upd   = idle_name;
            if (idle_num) begin
                acc_next = NUMBER_BITS'(c_digit_val);
                ovf_next = 1'b0;
            end
        end
    end

    // Next values of name, line and halt state
    always_comb begin
        cand_next     = cand_reg;
        name_len_next = name_len_reg;
        if (name_upd) begin
            cand_next     = nc_mask;
            name_len_next = (nc_pos == '1) ? nc_pos : nc_pos + LB'(1);
        end
        line_next = line_reg;
        if ((comment_bump || (do_idle && idle_bump)) && line_reg != '1) begin
            line_next = line_reg + LINE_BITS'(1);
        end
        halted_next = pre_halt || (do_idle && idle_halt);
    end

    // Assemble up to two results
    always_comb begin
        result_t r_pre, r_idle;
        r_pre.last   = 1'b0;
        r_pre.err    = pre_err;
        r_pre.kind   = pre_kind;
        r_pre.line   = line_reg;
        r_pre.value  = pre_value;
        r_pre.ch     = '0;
        r_idle.last  = 1'b1;
        r_idle.err   = idle_err;
        r_idle.kind  = idle_kind;
        r_idle.line  = line_reg;
        r_idle.value = '0;
        r_idle.ch    = idle_ch;

        res_cnt = 2'd0;
        if (advance && !halted_reg) begin
            res_cnt = 2'(pre_v) + 2'(do_idle && idle_emit);
        end
        res0      = pre_v ? r_pre : r_idle;
        res0.last = (res_cnt == 2'd1);
        res1      = r_idle;
    end

    // Update scanner state once per taken character, unless halted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= pl0ts_pkg::MODE_IDLE;
            cand_reg     <= '1;
            name_len_reg <= '0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            line_reg     <= LINE_BITS'(1);
            halted_reg   <= 1'b0;
        end else if (advance && !halted_reg) begin
            mode_reg     <= mode_next;
            cand_reg     <= cand_next;
            name_len_reg <= name_len_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            line_reg     <= line_next;
            halted_reg   <= halted_next;
        end
    end

    pl0ts_result_queue #(
        .ITEM_BITS (ITEM_BITS)
    ) u_result_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_cnt   (res_cnt),
        .wr_data0 (res0),
        .wr_data1 (res1),
        .room     (q_room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (q_out)
    );

    // Drive the result channel from the queue head
    generate
        if (PAD_BITS > 0) begin : g_pad
            assign m_tdata = {{PAD_BITS{1'b0}}, q_out.line, q_out.value, q_out.ch};
        end else begin : g_nopad
            assign m_tdata = {q_out.line, q_out.value, q_out.ch};
        end
    endgenerate
    assign m_tuser = {q_out.err, q_out.kind};
    assign m_tlast = q_out.last;

endmodule

/* tb/pl0_token_scanner_checker.sv */
`timescale 1ns / 1ps
// Token checker for the PL/0 scanner: predicts tokens from accepted characters and compares.
module pl0_token_scanner_checker
    import pl0ts_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_code
    input  logic       m_tvalid,
    input  logic       m_tready,
    // [7:0] token_char, then number_value, then line_number, zero padded
    input  logic [((CHAR_BITS + NUMBER_BITS + LINE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic [6:0] m_tuser,    // [3:0] token_kind, [6:4] error_code
    input  logic       m_tlast,    // last_of_run
    output int         mismatches,
    output int         tokens_due
);

    localparam logic [7:0]             CH_EOT     = 8'h00;
    localparam logic [7:0]             DIGIT_ZERO = "0";
    localparam logic [NUMBER_BITS-1:0] NUM_MAX    = '1;

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [CHAR_BITS-1:0]   ch;
        logic [NUMBER_BITS-1:0] value;
        logic [LINE_BITS-1:0]   line;
        logic [ERR_BITS-1:0]    err;
        logic                   ends_run;
    } token_t;

    string keywords [KW_COUNT] = '{
        "const", "var", "procedure", "call", "begin", "end",
        "if", "then", "while", "do", "odd"
    };

    token_t pending_tokens [$];
    token_t run_buf [2];
    int     run_len;

    // Scanner state as the block should hold it
    scan_mode_t             mode;
    logic [KW_COUNT-1:0]    kw_live;
    logic [3:0]             name_len;
    logic [NUMBER_BITS-1:0] num_acc;
    logic                   num_ovf;
    logic [LINE_BITS-1:0]   line_cnt;
    logic                   halted;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        case (c)
            ".", "=", ",", ";", "#", "<", ">", "+", "-", "*", "/", "(", ")": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // First keyword still alive whose length equals the name length, else identifier
    function automatic logic [KIND_BITS-1:0] name_kind();
        logic [KIND_BITS-1:0] kind;
        kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (kw_live[k] && keywords[k].len() == name_len) begin
                kind = KIND_KW_BASE + KIND_BITS'(k);
            end
        end
        return kind;
    endfunction

    task automatic emit_token(input logic [KIND_BITS-1:0] kind, input logic [7:0] ch,
                              input logic [NUMBER_BITS-1:0] value,
                              input logic [ERR_BITS-1:0] err);
        run_buf[run_len] = '{kind, ch, value, line_cnt, err, 1'b0};
        run_len++;
    endtask

    task automatic raise_error(input logic [ERR_BITS-1:0] err);
        emit_token(KIND_END, '0, '0, err);
        halted = 1'b1;
    endtask

    task automatic count_line();
        if (line_cnt != '1) begin
            line_cnt++;
        end
    endtask

    // Drop keywords that no longer match at this position; saturate the length
    task automatic name_letter(input logic [7:0] c);
        for (int k = 0; k < KW_COUNT; k++) begin
            if (name_len >= keywords[k].len() || keywords[k][name_len] != c) begin
                kw_live[k] = 1'b0;
            end
        end
        if (name_len != 4'd15) begin
            name_len++;
        end
    endtask

    task automatic scan_idle(input logic [7:0] c);
        mode = MODE_IDLE;
        if (c == " " || c == "\t") begin
            // skip blanks
        end else if (c == "\n") begin
            count_line();
        end else if (is_letter(c) || c == "_") begin
            mode     = MODE_NAME;
            kw_live  = '1;
            name_len = '0;
            name_letter(c);
        end else if (is_digit(c)) begin
            mode    = MODE_NUM;
            num_acc = NUMBER_BITS'(c - DIGIT_ZERO);
            num_ovf = 1'b0;
        end else if (c == "{") begin
            mode = MODE_COMMENT;
        end else if (c == ":") begin
            mode = MODE_COLON;
        end else if (c == CH_EOT) begin
            emit_token(KIND_END, '0, '0, ERR_NONE);
        end else if (is_punct(c)) begin
            emit_token(KIND_PUNCT, c, '0, ERR_NONE);
        end else begin
            raise_error(ERR_UNKNOWN_CHAR);
        end
    endtask

    // Advance the predicted scanner by one character and queue its tokens
    task automatic scan_char(input logic [7:0] c);
        logic [NUMBER_BITS-1:0] digit;
        run_len = 0;
        if (!halted) begin
            digit = NUMBER_BITS'(8'(c - DIGIT_ZERO));
            case (mode)
                MODE_NAME: begin
                    if (is_letter(c) || is_digit(c) || c == "_") begin
                        name_letter(c);
                    end else begin
                        emit_token(name_kind(), '0, '0, ERR_NONE);
                        scan_idle(c);
                    end
                end
                MODE_NUM: begin
                    if (is_digit(c)) begin
                        // freeze the value once the next digit would not fit
                        if (!num_ovf) begin
                            if (num_acc > (NUM_MAX - digit) / 10) begin
                                num_ovf = 1'b1;
                            end else begin
                                num_acc = num_acc * 10 + digit;
                            end
                        end
                    end else if (c != "_") begin
                        mode = MODE_IDLE;
                        // an overflowed number swallows the byte that ends it
                        if (num_ovf) begin
                            raise_error(ERR_OVERFLOW);
                        end else begin
                            emit_token(KIND_NUMBER, '0, num_acc, ERR_NONE);
                            scan_idle(c);
                        end
                    end
                end
                MODE_COLON: begin
                    mode = MODE_IDLE;
                    if (c == "=") begin
                        emit_token(KIND_ASSIGN, '0, '0, ERR_NONE);
                    end else begin
                        raise_error(ERR_BAD_COLON);
                    end
                end
                MODE_COMMENT: begin
                    if (c == "}") begin
                        mode = MODE_IDLE;
                    end else if (c == CH_EOT) begin
                        mode = MODE_IDLE;
                        raise_error(ERR_OPEN_COMMENT);
                    end else if (c == "\n") begin
                        count_line();
                    end
                end
                default: begin
                    scan_idle(c);
                end
            endcase
            if (run_len > 0) begin
                run_buf[run_len - 1].ends_run = 1'b1;
            end
            for (int k = 0; k < run_len; k++) begin
                pending_tokens.push_back(run_buf[k]);
            end
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    // Watch both channels; predict on input transactions, compare on output ones
    always @(posedge aclk) begin : watch
        token_t want;
        if (!aresetn) begin
            mode     = MODE_IDLE;
            kw_live  = '1;
            name_len = '0;
            num_acc  = '0;
            num_ovf  = 1'b0;
            line_cnt = LINE_BITS'(1);
            halted   = 1'b0;
            pending_tokens.delete();
            mismatches = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                scan_char(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (pending_tokens.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected token: expected none, actual kind %0d error %0d",
                             $time, m_tuser[KIND_BITS-1:0], m_tuser[KIND_BITS +: ERR_BITS]);
                end else begin
                    want = pending_tokens.pop_front();
                    check_field("token_kind", want.kind, m_tuser[KIND_BITS-1:0]);
                    check_field("token_char", want.ch, m_tdata[CHAR_BITS-1:0]);
                    check_field("number_value", want.value, m_tdata[CHAR_BITS +: NUMBER_BITS]);
                    check_field("line_number", want.line,
                                m_tdata[CHAR_BITS + NUMBER_BITS +: LINE_BITS]);
                    check_field("error_code", want.err, m_tuser[KIND_BITS +: ERR_BITS]);
                    check_field("last_of_run", want.ends_run, m_tlast);
                end
            end
        end
        tokens_due = pending_tokens.size();
    end

endmodule

/* tb/pl0_token_scanner_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the PL/0 token scanner: clock, reset, character stimulus and verdict.
module pl0_token_scanner_core_tb;
    import pl0ts_pkg::*;

    localparam int TDATA_BITS    = ((CHAR_BITS + NUMBER_BITS_DEF + LINE_BITS_DEF + 7) / 8) * 8;
    localparam int CHAR_GOAL     = 1300;
    localparam int HOLD_AT       = 400;
    localparam int DRAIN_AT      = 800;
    localparam int QUIET_AT      = 1150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 5_000_000;

    localparam logic [7:0] CH_EOT     = 8'h00;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] DIGIT_ZERO = "0";

    string keywords [KW_COUNT] = '{
        "const", "var", "procedure", "call", "begin", "end",
        "if", "then", "while", "do", "odd"
    };
    // letters and underscore first, so the head of a name is drawn from indexes 0..52
    string name_chars    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    string punct_marks   = ".=,;#<>+-*/()";
    string unknown_marks = "!$%&?@[]^`|~\"'\\";

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_tdata;
    logic [6:0]            m_tuser;
    logic                  m_tlast;

    int mismatches;
    int tokens_due;
    int sent        = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit quiet       = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    bit drained     = 1'b0;

    pl0_token_scanner_core #(
        .NUMBER_BITS (NUMBER_BITS_DEF),
        .LINE_BITS   (LINE_BITS_DEF)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    pl0_token_scanner_checker #(
        .NUMBER_BITS (NUMBER_BITS_DEF),
        .LINE_BITS   (LINE_BITS_DEF)
    ) i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .tokens_due (tokens_due)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    // Idle density for the next stretch: none, light or heavy
    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 50;
        endcase
    endfunction

    // Offer one character, hold it until the transaction, then maybe idle a burst
    task automatic push_char(input logic [7:0] c);
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sent++;
        if ($urandom_range(0, 63) == 0) begin
            tx_idle_pct = pick_idle_pct();
        end
        if (!quiet && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
    endtask

    task automatic push_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            push_char(text[i]);
        end
    endtask

    // Keyword, keyword with a tail, keyword prefix, or a random name up to 20 long
    task automatic push_word();
        string kw;
        kw = keywords[$urandom_range(0, KW_COUNT - 1)];
        case ($urandom_range(0, 4))
            0, 1: push_text(kw);
            2: begin
                push_text(kw);
                repeat ($urandom_range(1, 3)) push_char(name_chars[$urandom_range(0, 62)]);
            end
            3: push_text(kw.substr(0, kw.len() - 2));
            default: begin
                push_char(name_chars[$urandom_range(0, 52)]);
                repeat ($urandom_range(0, 19)) push_char(name_chars[$urandom_range(0, 62)]);
            end
        endcase
    endtask

    // Numbers that fit: the largest value, values just below or at it, zero, up to 18 digits
    task automatic push_number();
        int digits;
        case ($urandom_range(0, 5))
            0: push_text("9223372036854775807");
            1: begin
                push_text("922337203685477580");
                push_char(DIGIT_ZERO + 8'($urandom_range(0, 7)));
            end
            2: push_char(DIGIT_ZERO);
            default: begin
                digits = $urandom_range(1, 18);
                push_char(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                repeat (digits - 1) begin
                    if ($urandom_range(0, 5) == 0) begin
                        push_char("_");
                    end
                    push_char(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                end
            end
        endcase
        // a letter right after the digits ends the number and starts a name
        if ($urandom_range(0, 7) == 0) begin
            push_word();
        end
    endtask

    // Comment body of nonzero bytes other than a closing brace, and newlines
    task automatic push_comment();
        logic [7:0] b;
        push_char("{");
        repeat ($urandom_range(0, 10)) begin
            b = 8'($urandom_range(1, 255));
            if (b == "}" || $urandom_range(0, 3) == 0) begin
                b = "\n";
            end
            push_char(b);
        end
        push_char("}");
    endtask

    task automatic push_separator();
        case ($urandom_range(0, 8))
            0, 1: push_char(" ");
            2: push_char("\t");
            3: push_char("\n");
            4: push_char(punct_marks[$urandom_range(0, 12)]);
            5: push_char(CH_EOT);
            6: push_comment();
            7: push_text(":=");
            default: push_text(" \n");
        endcase
    endtask

    // Output side: random ready bursts, one long hold once the sender asks for it
    initial begin : result_sink
        int hold_left;
        wait (aresetn);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
                    @(posedge aclk);
                end
            end else if (!quiet && $urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
            if ($urandom_range(0, 63) == 0) begin
                rx_idle_pct = pick_idle_pct();
            end
        end
    end

    initial begin : stimulus
        logic [7:0] b;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: keyword, name with underscore, zero, comment with extreme bytes,
        // assign, punctuation, end of input, then the largest number
        push_text("odd _a1 0{\n");
        push_char(8'hFF);
        push_char(8'h01);
        push_text("}:=+\n");
        push_char(CH_EOT);
        push_text("9223372036854775807)");

        // Random token stream; every token is followed by a separator
        while (sent < CHAR_GOAL) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_word();
                4, 5: push_number();
                6: push_comment();
                7, 8: push_char(punct_marks[$urandom_range(0, 12)]);
                default: push_char(CH_EOT);
            endcase
            push_separator();
            if (sent >= HOLD_AT) begin
                hold_req = 1'b1;
            end
            // pause the sender until every pending token has come out
            if (!drained && sent >= DRAIN_AT) begin
                drained = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait (tokens_due == 0);
                @(posedge aclk);
            end
            if (sent >= QUIET_AT) begin
                quiet = 1'b1;
            end
        end
        quiet = 1'b1;

        // One error to finish, since only reset clears the halt
        case (ERR_BITS'($urandom_range(1, 4)))
            ERR_OPEN_COMMENT: begin
                push_char("{");
                repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(1, 124)));
                push_char(CH_EOT);
            end
            ERR_BAD_COLON: begin
                if ($urandom_range(0, 1) == 1) begin
                    push_word();
                end
                push_char(":");
                do b = 8'($urandom_range(0, 255)); while (b == "=");
                push_char(b);
            end
            ERR_UNKNOWN_CHAR: begin
                if ($urandom_range(0, 1) == 1) begin
                    push_word();
                end
                case ($urandom_range(0, 3))
                    0: b = CH_CR;
                    1: b = 8'($urandom_range(128, 255));
                    2: b = 8'($urandom_range(1, 8));
                    default: b = unknown_marks[$urandom_range(0, unknown_marks.len() - 1)];
                endcase
                push_char(b);
            end
            default: begin
                if ($urandom_range(0, 1) == 1) begin
                    push_text("9223372036854775808");
                end else begin
                    push_text("99999_99999_99999_99999");
                end
                do b = 8'($urandom_range(0, 255)); while ((b >= "0" && b <= "9") || b == "_");
                push_char(b);
            end
        endcase

        // Halted: these are taken and dropped
        repeat (8) push_char(8'($urandom_range(0, 255)));
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (tokens_due == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
design/pl0ts_pkg.sv
design/pl0ts_result_queue.sv
design/pl0_token_scanner_core.sv
tb/pl0_token_scanner_checker.sv
tb/pl0_token_scanner_core_tb.sv
